@@ hw/rtl/jsu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CountW  = 2;
  localparam int unsigned CpW     = 16;
  localparam int unsigned HexCntW = 2;

  // Result codes carried in the status field.
  typedef enum logic [StatusW-1:0] {
    ST_DATA    = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_BAD_ESC = 3'd2,
    ST_BAD_U   = 3'd3,
    ST_UNTERM  = 3'd4
  } status_e;

  // Decoder phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BODY = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_e;

  // Characters of interest.
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChN = 8'h6E;
  localparam logic [ByteW-1:0] ChT = 8'h74;
  localparam logic [ByteW-1:0] ChR = 8'h72;
  localparam logic [ByteW-1:0] ChB = 8'h62;
  localparam logic [ByteW-1:0] ChF = 8'h66;
  localparam logic [ByteW-1:0] ChU = 8'h75;
  localparam logic [ByteW-1:0] CtlLf = 8'h0A;
  localparam logic [ByteW-1:0] CtlTab = 8'h09;
  localparam logic [ByteW-1:0] CtlCr = 8'h0D;
  localparam logic [ByteW-1:0] CtlBs = 8'h08;
  localparam logic [ByteW-1:0] CtlFf = 8'h0C;

  // UTF-8 lead and continuation markers.
  localparam logic [ByteW-1:0] Utf8Cont = 8'h80;
  localparam logic [ByteW-1:0] Utf8Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Utf8Lead3 = 8'hE0;

  // Up to three results produced by one input item.
  typedef struct packed {
    logic [CountW-1:0]                count;
    logic [MaxRes-1:0][ByteW-1:0]     bytes;
    logic [MaxRes-1:0][StatusW-1:0]   status;
    logic [MaxRes-1:0]                last;
  } res_t;

  // Returns {valid, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/jsu_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Holds the parse state and turns one registered input item into its results.
module jsu_decode (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [jsu_pkg::ByteW-1:0]   byte_i,
  input  wire logic                        eot_i,
  input  wire logic                        take_i,
  output jsu_pkg::res_t                    res_o
);

  jsu_pkg::phase_e                    phase_q, phase_d;
  logic [jsu_pkg::HexCntW-1:0]        hex_cnt_q, hex_cnt_d;
  logic [jsu_pkg::CpW-1:0]            cp_q, cp_d;
  logic [4:0]                         hex;
  logic [jsu_pkg::CpW-1:0]            cp_new;
  logic [jsu_pkg::ByteW-1:0]          esc_val;
  logic                               esc_ok;

  function automatic jsu_pkg::res_t single(input logic [jsu_pkg::ByteW-1:0] b,
                                           input jsu_pkg::status_e st);
    jsu_pkg::res_t r;
    r           = '0;
    r.count     = 2'd1;
    r.bytes[0]  = b;
    r.status[0] = st;
    r.last[0]   = 1'b1;
    return r;
  endfunction

  assign hex    = jsu_pkg::hex_digit(byte_i);
  assign cp_new = {cp_q[jsu_pkg::CpW-5:0], hex[3:0]};

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = byte_i;
    case (byte_i)
      jsu_pkg::ChQuote:  esc_val = jsu_pkg::ChQuote;
      jsu_pkg::ChBslash: esc_val = jsu_pkg::ChBslash;
      jsu_pkg::ChSlash:  esc_val = jsu_pkg::ChSlash;
      jsu_pkg::ChN:      esc_val = jsu_pkg::CtlLf;
      jsu_pkg::ChT:      esc_val = jsu_pkg::CtlTab;
      jsu_pkg::ChR:      esc_val = jsu_pkg::CtlCr;
      jsu_pkg::ChB:      esc_val = jsu_pkg::CtlBs;
      jsu_pkg::ChF:      esc_val = jsu_pkg::CtlFf;
      default:           esc_ok  = 1'b0;
    endcase
  end

  always_comb begin
    res_o     = '0;
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    case (phase_q)
      jsu_pkg::PH_BODY: begin
        if (eot_i) begin
          res_o   = single('0, jsu_pkg::ST_UNTERM);
          phase_d = jsu_pkg::PH_IDLE;
        end else if (byte_i == jsu_pkg::ChQuote) begin
          res_o   = single('0, jsu_pkg::ST_CLOSED);
          phase_d = jsu_pkg::PH_IDLE;
        end else if (byte_i == jsu_pkg::ChBslash) begin
          phase_d = jsu_pkg::PH_ESC;
        end else begin
          res_o = single(byte_i, jsu_pkg::ST_DATA);
        end
      end
      jsu_pkg::PH_ESC: begin
        if (eot_i) begin
          res_o   = single('0, jsu_pkg::ST_BAD_ESC);
          phase_d = jsu_pkg::PH_IDLE;
        end else if (byte_i == jsu_pkg::ChU) begin
          phase_d   = jsu_pkg::PH_HEX;
          hex_cnt_d = '0;
          cp_d      = '0;
        end else if (esc_ok) begin
          res_o   = single(esc_val, jsu_pkg::ST_DATA);
          phase_d = jsu_pkg::PH_BODY;
        end else begin
          res_o   = single('0, jsu_pkg::ST_BAD_ESC);
          phase_d = jsu_pkg::PH_IDLE;
        end
      end
      jsu_pkg::PH_HEX: begin
        if (eot_i || !hex[4]) begin
          res_o     = single('0, jsu_pkg::ST_BAD_U);
          phase_d   = jsu_pkg::PH_IDLE;
          hex_cnt_d = '0;
          cp_d      = '0;
        end else if (hex_cnt_q != 2'd3) begin
          cp_d      = cp_new;
          hex_cnt_d = hex_cnt_q + 2'd1;
        end else begin
          // Fourth digit: encode the code point as UTF-8.
          if (cp_new[15:7] == '0) begin
            res_o = single({1'b0, cp_new[6:0]}, jsu_pkg::ST_DATA);
          end else if (cp_new[15:11] == '0) begin
            res_o.count    = 2'd2;
            res_o.bytes[0] = jsu_pkg::Utf8Lead2 | {3'b0, cp_new[10:6]};
            res_o.bytes[1] = jsu_pkg::Utf8Cont | {2'b0, cp_new[5:0]};
            res_o.last[1]  = 1'b1;
          end else begin
            res_o.count    = 2'd3;
            res_o.bytes[0] = jsu_pkg::Utf8Lead3 | {4'b0, cp_new[15:12]};
            res_o.bytes[1] = jsu_pkg::Utf8Cont | {2'b0, cp_new[11:6]};
            res_o.bytes[2] = jsu_pkg::Utf8Cont | {2'b0, cp_new[5:0]};
            res_o.last[2]  = 1'b1;
          end
          phase_d   = jsu_pkg::PH_BODY;
          hex_cnt_d = '0;
          cp_d      = '0;
        end
      end
      default: begin
        // Idle: any byte counts as the opening quote.
        phase_d = eot_i ? jsu_pkg::PH_IDLE : jsu_pkg::PH_BODY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= jsu_pkg::PH_IDLE;
      hex_cnt_q <= '0;
      cp_q      <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/jsu_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Result register, three entries deep, drained one entry per cycle while the receiver is ready.
module jsu_outbuf (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pend_i,
  input  wire jsu_pkg::res_t                 res_i,
  output logic                               take_o,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [jsu_pkg::ByteW-1:0]          byte_o,
  output logic [jsu_pkg::StatusW-1:0]        status_o,
  output logic                               last_o
);

  logic [jsu_pkg::CountW-1:0]                       cnt_q, cnt_d;
  logic [jsu_pkg::MaxRes-1:0][jsu_pkg::ByteW-1:0]   byte_q, byte_d;
  logic [jsu_pkg::MaxRes-1:0][jsu_pkg::StatusW-1:0] status_q, status_d;
  logic [jsu_pkg::MaxRes-1:0]                       last_q, last_d;
  logic                                             pop;

  assign valid_o  = (cnt_q != '0);
  assign pop      = valid_o && ready_i;
  // A new item is loaded only when the buffer will be empty after this cycle.
  assign take_o   = pend_i && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop));
  assign byte_o   = byte_q[0];
  assign status_o = status_q[0];
  assign last_o   = last_q[0];

  always_comb begin
    cnt_d    = cnt_q;
    byte_d   = byte_q;
    status_d = status_q;
    last_d   = last_q;
    if (take_o) begin
      cnt_d    = res_i.count;
      byte_d   = res_i.bytes;
      status_d = res_i.status;
      last_d   = res_i.last;
    end else if (pop) begin
      cnt_d       = cnt_q - 2'd1;
      byte_d[0]   = byte_q[1];
      byte_d[1]   = byte_q[2];
      status_d[0] = status_q[1];
      status_d[1] = status_q[2];
      last_d[0]   = last_q[1];
      last_d[1]   = last_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/json_string_unescaper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Unescapes the body of a JSON string, one text byte per input item.
// Input stream: tdata carries the text byte, tuser flags end of text (the
// byte is then ignored). The first byte after reset or after a finished
// string is taken as the opening quote and produces nothing.
// Output stream: tdata carries the decoded byte and a status code (data,
// string closed, bad escape, bad unicode escape, unterminated); tlast marks
// the final result caused by one input item.
// An accepted item waits in the input register and is decoded into the
// result register once the result register can take it; its results are
// offered from there.
// Throughput is one item per cycle while the receiver keeps up. Only the
// fourth hex digit of a \u escape yields two or three UTF-8 bytes; the
// result register then drains one byte per cycle while the receiver is
// ready and holds off the next item until it is nearly empty.
// Reset clears the input and result valid state and returns the parser to
// idle, awaiting an opening quote.
// When the receiver stalls, results wait in the result register and the
// input side keeps accepting until the input register is also full.
module json_string_unescaper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser_i,  // [0] end_of_text
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [7:0] out_byte, [10:8] status
  output logic             m_axis_tlast_o
);

  logic                             in_valid_q;
  logic [jsu_pkg::ByteW-1:0]        in_byte_q;
  logic                             in_eot_q;
  logic                             take;
  jsu_pkg::res_t                    res;
  logic [jsu_pkg::ByteW-1:0]        out_byte;
  logic [jsu_pkg::StatusW-1:0]      out_status;

  // The input register frees up in the same cycle its item is consumed.
  assign s_axis_tready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eot_q  <= s_axis_tuser_i[0];
    end
  end

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .eot_i  (in_eot_q),
    .take_i (take),
    .res_o  (res)
  );

  jsu_outbuf u_outbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pend_i   (in_valid_q),
    .res_i    (res),
    .take_o   (take),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .byte_o   (out_byte),
    .status_o (out_status),
    .last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b0, out_status, out_byte};

endmodule

`default_nettype wire

@@ hw/rtl/jsu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_i,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_i,
  input wire logic        m_axis_tlast_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))
    else $error("result changed while stalled");

  // Closing and error results end their item and carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[10:8] != jsu_pkg::ST_DATA |->
      m_axis_tlast_i && m_axis_tdata_i[7:0] == 8'h00)
    else $error("non-data result malformed");

  // Only defined status codes appear, and padding bits stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |->
      m_axis_tdata_i[10:8] <= jsu_pkg::ST_UNTERM && m_axis_tdata_i[15:11] == 5'd0)
    else $error("bad status or padding");

  // A result that does not end its item is part of a multi-byte UTF-8
  // sequence, so it is data with the top bit set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tlast_i |->
      m_axis_tdata_i[10:8] == jsu_pkg::ST_DATA && m_axis_tdata_i[7])
    else $error("multi-byte sequence malformed");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire

@@ sim/jsu_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams of the unescaper, predicts the results of every
// accepted input item and compares them with what comes out.
module jsu_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] end_of_text
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [7:0] out_byte, [10:8] status
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0]        value;
    jsu_pkg::status_e  status;
    logic              last;
  } decoded_t;

  decoded_t          decoded_q[$];
  jsu_pkg::phase_e   phase_q;
  logic [1:0]        digits_taken;
  logic [15:0]       cp_acc;
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Returns {is_hex, nibble}. Letters of either case have 1..6 in the low
  // nibble, so adding nine gives their value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  // Returns {is_escape, decoded byte} for the letter after a backslash.
  function automatic logic [8:0] escape_value(input logic [7:0] c);
    case (c)
      jsu_pkg::ChQuote:  return {1'b1, jsu_pkg::ChQuote};
      jsu_pkg::ChBslash: return {1'b1, jsu_pkg::ChBslash};
      jsu_pkg::ChSlash:  return {1'b1, jsu_pkg::ChSlash};
      jsu_pkg::ChN:      return {1'b1, jsu_pkg::CtlLf};
      jsu_pkg::ChT:      return {1'b1, jsu_pkg::CtlTab};
      jsu_pkg::ChR:      return {1'b1, jsu_pkg::CtlCr};
      jsu_pkg::ChB:      return {1'b1, jsu_pkg::CtlBs};
      jsu_pkg::ChF:      return {1'b1, jsu_pkg::CtlFf};
      default:           return 9'd0;
    endcase
  endfunction

  task automatic push_decoded(input logic [7:0] value, input jsu_pkg::status_e st,
                              input logic last);
    decoded_t d;
    d.value   = value;
    d.status  = st;
    d.last    = last;
    decoded_q = {decoded_q, d};
  endtask

  // Any closing event gives a single status result and drops back to idle.
  task automatic close_string(input jsu_pkg::status_e st);
    push_decoded(8'h00, st, 1'b1);
    phase_q      = jsu_pkg::PH_IDLE;
    digits_taken = '0;
    cp_acc       = '0;
  endtask

  task automatic decode_item(input logic [7:0] text, input logic eot);
    logic [4:0]  digit;
    logic [8:0]  esc;
    logic [15:0] cp;
    digit = hex_nibble(text);
    esc   = escape_value(text);
    case (phase_q)
      jsu_pkg::PH_BODY: begin
        if (eot) close_string(jsu_pkg::ST_UNTERM);
        else if (text == jsu_pkg::ChQuote) close_string(jsu_pkg::ST_CLOSED);
        else if (text == jsu_pkg::ChBslash) phase_q = jsu_pkg::PH_ESC;
        else push_decoded(text, jsu_pkg::ST_DATA, 1'b1);
      end
      jsu_pkg::PH_ESC: begin
        if (eot) begin
          close_string(jsu_pkg::ST_BAD_ESC);
        end else if (text == jsu_pkg::ChU) begin
          phase_q      = jsu_pkg::PH_HEX;
          digits_taken = '0;
          cp_acc       = '0;
        end else if (esc[8]) begin
          phase_q = jsu_pkg::PH_BODY;
          push_decoded(esc[7:0], jsu_pkg::ST_DATA, 1'b1);
        end else begin
          close_string(jsu_pkg::ST_BAD_ESC);
        end
      end
      jsu_pkg::PH_HEX: begin
        if (eot || !digit[4]) begin
          close_string(jsu_pkg::ST_BAD_U);
        end else begin
          cp = {cp_acc[11:0], digit[3:0]};
          if (digits_taken != 2'd3) begin
            cp_acc       = cp;
            digits_taken = digits_taken + 2'd1;
          end else begin
            // Fourth digit: emit the code point as UTF-8, one to three bytes.
            if (cp < 16'h0080) begin
              push_decoded(cp[7:0], jsu_pkg::ST_DATA, 1'b1);
            end else if (cp < 16'h0800) begin
              push_decoded(jsu_pkg::Utf8Lead2 | {3'b000, cp[10:6]}, jsu_pkg::ST_DATA, 1'b0);
              push_decoded(jsu_pkg::Utf8Cont | {2'b00, cp[5:0]}, jsu_pkg::ST_DATA, 1'b1);
            end else begin
              push_decoded(jsu_pkg::Utf8Lead3 | {4'b0000, cp[15:12]}, jsu_pkg::ST_DATA,
                           1'b0);
              push_decoded(jsu_pkg::Utf8Cont | {2'b00, cp[11:6]}, jsu_pkg::ST_DATA, 1'b0);
              push_decoded(jsu_pkg::Utf8Cont | {2'b00, cp[5:0]}, jsu_pkg::ST_DATA, 1'b1);
            end
            phase_q      = jsu_pkg::PH_BODY;
            digits_taken = '0;
            cp_acc       = '0;
          end
        end
      end
      default: phase_q = eot ? jsu_pkg::PH_IDLE : jsu_pkg::PH_BODY;
    endcase
  endtask

  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                m_axis_tdata_i, m_axis_tlast_i));
      return;
    end
    want = decoded_q.pop_front();
    if (m_axis_tdata_i[7:0] !== want.value) begin
      report_mismatch($sformatf("out_byte %h, expected %h", m_axis_tdata_i[7:0], want.value));
    end
    if (m_axis_tdata_i[10:8] !== want.status) begin
      report_mismatch($sformatf("status %0d, expected %0d", m_axis_tdata_i[10:8],
                                want.status));
    end
    if (m_axis_tlast_i !== want.last) begin
      report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast_i, want.last));
    end
    if (m_axis_tdata_i[15:11] !== 5'd0) begin
      report_mismatch($sformatf("tdata padding %h is not zero", m_axis_tdata_i[15:11]));
    end
  endtask

  // Inputs move on the falling edge, so everything is stable here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      = jsu_pkg::PH_IDLE;
      digits_taken = '0;
      cp_acc       = '0;
      decoded_q.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) decode_item(s_axis_tdata_i, s_axis_tuser_i[0]);
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
    end
    pending_o = decoded_q.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int RandomItems = 410;
  localparam int unsigned MaxIdle     = 17;
  localparam int unsigned StallCycles = 300;
  localparam int unsigned DrainLimit  = 20000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic [0:0]  s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  int mismatches;
  int results_pending;
  int items_sent = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit stall_request = 1'b0;

  json_string_unescaper u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  jsu_scoreboard u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (mismatches),
    .pending_o       (results_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #2000000;
    $display("json_string_unescaper regression: fail");
    $finish;
  end

  // Offers one item after a random gap and returns on the falling edge that
  // follows its acceptance, so the next item can be put up at once.
  task automatic send_item(input logic [7:0] text, input logic eot);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= text;
    s_tuser  <= eot;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // End of text carries a random byte that the block must ignore.
  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [7:0] escape_letter(input int unsigned idx);
    case (idx)
      0:       return jsu_pkg::ChQuote;
      1:       return jsu_pkg::ChBslash;
      2:       return jsu_pkg::ChSlash;
      3:       return jsu_pkg::ChN;
      4:       return jsu_pkg::ChT;
      5:       return jsu_pkg::ChR;
      6:       return jsu_pkg::ChB;
      default: return jsu_pkg::ChF;
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == jsu_pkg::ChQuote || c == jsu_pkg::ChBslash);
    return c;
  endfunction

  // A letter that is neither a known escape nor the start of a \u escape.
  function automatic logic [7:0] bad_escape_letter();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash, jsu_pkg::ChN,
                     jsu_pkg::ChT, jsu_pkg::ChR, jsu_pkg::ChB, jsu_pkg::ChF, jsu_pkg::ChU});
    return c;
  endfunction

  // Something that breaks a \u escape; a closing quote now and then.
  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    if ($urandom_range(0, 2) == 0) return jsu_pkg::ChQuote;
    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
    return c;
  endfunction

  // Code points spread over the one, two and three byte encodings, with the
  // surrogate range given a share of its own.
  function automatic logic [15:0] random_code_point();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       return 16'($urandom_range(16'hD800, 16'hDFFF));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send_unicode(input logic [15:0] cp);
    send_item(jsu_pkg::ChBslash, 1'b0);
    send_item(jsu_pkg::ChU, 1'b0);
    for (int i = 3; i >= 0; i--) send_item(hex_char(cp[i*4 +: 4]), 1'b0);
  endtask

  // One string with random content. Most close with a quote; the rest end
  // in each of the error paths so that the block is seen returning to idle.
  task automatic send_string();
    int tokens;
    int digits;
    send_item(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : jsu_pkg::ChQuote,
              1'b0);
    tokens = $urandom_range(0, 6);
    repeat (tokens) begin
      case ($urandom_range(0, 3))
        0, 1: send_item(plain_byte(), 1'b0);
        2: begin
          send_item(jsu_pkg::ChBslash, 1'b0);
          send_item(escape_letter($urandom_range(0, 7)), 1'b0);
        end
        default: send_unicode(random_code_point());
      endcase
    end
    case ($urandom_range(0, 9))
      0: send_end();
      1: begin
        send_item(jsu_pkg::ChBslash, 1'b0);
        if ($urandom_range(0, 2) == 0) send_end();
        else send_item(bad_escape_letter(), 1'b0);
      end
      2: begin
        send_item(jsu_pkg::ChBslash, 1'b0);
        send_item(jsu_pkg::ChU, 1'b0);
        digits = $urandom_range(0, 3);
        repeat (digits) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
        if ($urandom_range(0, 2) == 0) send_end();
        else send_item(non_hex_byte(), 1'b0);
      end
      default: send_item(jsu_pkg::ChQuote, 1'b0);
    endcase
  endtask

  // Raw bytes with the odd end of text mixed in, then an end of text, which
  // brings the block back to idle from any phase.
  task automatic send_noise();
    int count;
    count = $urandom_range(1, 8);
    repeat (count) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    send_end();
  endtask

  // Result side. The wait before each result is counted here, and a stall
  // request from the stimulus turns one of them into a long hold-off.
  initial begin : receiver
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = rx_gaps ? $urandom_range(0, MaxIdle) : 0;
      if (stall_request) begin
        gap = StallCycles;
        stall_request = 1'b0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int target;
    int settle;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // End of text while idle is ignored.
    send_end();
    // Any byte opens a string, here the largest one.
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // The largest code point needs three bytes.
    send_unicode(16'hFFFF);
    send_item(jsu_pkg::ChQuote, 1'b0);
    // Text ends right after a backslash.
    send_item(jsu_pkg::ChQuote, 1'b0);
    send_item(jsu_pkg::ChBslash, 1'b0);
    send_end();
    // Unknown escape letter.
    send_item(jsu_pkg::ChQuote, 1'b0);
    send_item(jsu_pkg::ChBslash, 1'b0);
    send_item(8'h78, 1'b0);
    // A quote inside the hex digits breaks the \u escape.
    send_item(jsu_pkg::ChQuote, 1'b0);
    send_item(jsu_pkg::ChBslash, 1'b0);
    send_item(jsu_pkg::ChU, 1'b0);
    send_item(8'h31, 1'b0);
    send_item(jsu_pkg::ChQuote, 1'b0);
    // Text ends while hex digits are expected.
    send_item(jsu_pkg::ChQuote, 1'b0);
    send_item(jsu_pkg::ChBslash, 1'b0);
    send_item(jsu_pkg::ChU, 1'b0);
    send_end();
    // Text ends inside a plain string body.
    send_item(jsu_pkg::ChQuote, 1'b0);
    send_end();

    // Four random phases, each with its own mix of idling on the two sides.
    // The phase with a busy sender and an idling receiver also asks the
    // receiver for a long stall, so the block fills up and pushes back on its input.
    for (int p = 0; p < 4; p++) begin
      tx_gaps = (p == 0) || (p == 3);
      rx_gaps = (p == 0) || (p == 2);
      if (p == 2) stall_request = 1'b1;
      target = (p + 1) * RandomItems / 4;
      while (items_sent < target) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_string();
      end
    end
    s_tvalid <= 1'b0;

    settle = 0;
    while (results_pending != 0 && settle < DrainLimit) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && results_pending == 0) begin
      $display("json_string_unescaper regression: pass");
    end else begin
      $display("json_string_unescaper regression: fail");
    end
    $finish;
  end

endmodule
